// ----- rtl/core/midpoint_line_rasterizer_assert.svh -----
// Assertion macros used by the line rasterizer datapath.
`ifndef MIDPOINT_LINE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define MLR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define MLR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- rtl/core/mlr_pkg.sv -----
// Shared types and slope class codes of the line rasterizer.
package mlr_pkg;

  typedef logic [2:0] slope_class_t;

  localparam slope_class_t CLS_NONE         = 3'd0;
  localparam slope_class_t CLS_VERT         = 3'd1;
  localparam slope_class_t CLS_STEEP_UP     = 3'd2;
  localparam slope_class_t CLS_SHALLOW_RISE = 3'd3;
  localparam slope_class_t CLS_SHALLOW_FALL = 3'd4;
  localparam slope_class_t CLS_STEEP_FALL   = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } mlr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic steps_zero;
    logic last_step;
    logic out_free;
  } mlr_status_t;

endpackage

// ----- rtl/core/mlr_ctrl.sv -----
// Controller state machine of the line rasterizer.
module mlr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  mlr_pkg::mlr_status_t status,
  output mlr_pkg::mlr_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.steps_zero) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.last_step) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/mlr_datapath.sv -----
// Datapath of the line rasterizer: segment setup, walk registers and output register.
`include "midpoint_line_rasterizer_assert.svh"

module mlr_datapath #(
  parameter int COORD_BITS = 6,
  localparam int IN_W = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mlr_pkg::mlr_cmd_t    cmd,
  output mlr_pkg::mlr_status_t status,
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,
  output logic                 m_tlast
);

  localparam int CB  = COORD_BITS;
  localparam int D_W = COORD_BITS + 3;

  logic [CB-1:0] ax, ay, bx, by;
  logic [CB-1:0] sx, sy, ex, ey;
  logic          swap;
  logic signed [CB:0] dx_s;
  logic          dx_neg, dx_zero;
  logic [CB-1:0] adx, dy;
  logic signed [D_W-1:0] adx_w, dy_w;

  mlr_pkg::slope_class_t cls0;
  logic [CB-1:0]         x0, y0, n0;
  logic signed [D_W-1:0] d0;

  // Walk state.
  mlr_pkg::slope_class_t slope_class;
  logic [CB-1:0]         cur_x, cur_y, steps_left;
  logic signed [D_W-1:0] decision, two_adx, two_dy;
  logic [CB-1:0]         cur_x_next, cur_y_next;
  logic signed [D_W-1:0] decision_next;

  // Output register.
  logic [CB-1:0] out_x, out_y;
  logic          out_last;

  assign ax = s_tdata[CB-1:0];
  assign ay = s_tdata[2*CB-1:CB];
  assign bx = s_tdata[3*CB-1:2*CB];
  assign by = s_tdata[4*CB-1:3*CB];

  // Order the endpoints by y; the first endpoint wins a tie.
  assign swap = (ay > by);
  assign sx   = swap ? bx : ax;
  assign sy   = swap ? by : ay;
  assign ex   = swap ? ax : bx;
  assign ey   = swap ? ay : by;

  assign dx_s    = $signed({1'b0, ex}) - $signed({1'b0, sx});
  assign dx_neg  = dx_s[CB];
  assign dx_zero = (dx_s == '0);
  assign adx     = dx_neg ? CB'(-dx_s) : dx_s[CB-1:0];
  assign dy      = ey - sy;
  assign adx_w   = $signed(D_W'(adx));
  assign dy_w    = $signed(D_W'(dy));

  always_comb begin
    cls0 = mlr_pkg::CLS_NONE;
    x0   = sx;
    y0   = sy;
    d0   = '0;
    n0   = dy;
    priority if (dx_zero) begin
      cls0 = (dy == '0) ? mlr_pkg::CLS_NONE : mlr_pkg::CLS_VERT;
    end else if (!dx_neg && (dy > adx)) begin
      cls0 = mlr_pkg::CLS_STEEP_UP;
      d0   = (adx_w <<< 1) - dy_w;
    end else if (!dx_neg || (dy == '0)) begin
      // A horizontal segment given right to left starts at its left end.
      cls0 = mlr_pkg::CLS_SHALLOW_RISE;
      x0   = dx_neg ? ex : sx;
      y0   = dx_neg ? ey : sy;
      d0   = adx_w - (dy_w <<< 1);
      n0   = adx;
    end else if (dy <= adx) begin
      cls0 = mlr_pkg::CLS_SHALLOW_FALL;
      x0   = ex;
      y0   = ey;
      d0   = (dy_w <<< 1) - adx_w;
      n0   = adx;
    end else begin
      cls0 = mlr_pkg::CLS_STEEP_FALL;
      x0   = ex;
      y0   = ey;
      d0   = dy_w - (adx_w <<< 1);
    end
  end

  // One midpoint step of the current class.
  always_comb begin
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    decision_next = decision;
    unique case (slope_class)
      mlr_pkg::CLS_VERT: begin
        cur_y_next = cur_y + 1'b1;
      end
      mlr_pkg::CLS_STEEP_UP: begin
        cur_y_next = cur_y + 1'b1;
        if (decision >= 0) begin
          cur_x_next    = cur_x + 1'b1;
          decision_next = decision + two_adx - two_dy;
        end else begin
          decision_next = decision + two_adx;
        end
      end
      mlr_pkg::CLS_SHALLOW_RISE: begin
        cur_x_next = cur_x + 1'b1;
        if (decision < 0) begin
          cur_y_next    = cur_y + 1'b1;
          decision_next = decision + two_adx - two_dy;
        end else begin
          decision_next = decision - two_dy;
        end
      end
      mlr_pkg::CLS_SHALLOW_FALL: begin
        cur_x_next = cur_x + 1'b1;
        if (decision > 0) begin
          cur_y_next    = cur_y - 1'b1;
          decision_next = decision - two_adx + two_dy;
        end else begin
          decision_next = decision + two_dy;
        end
      end
      mlr_pkg::CLS_STEEP_FALL: begin
        cur_y_next = cur_y - 1'b1;
        if (decision < 0) begin
          cur_x_next    = cur_x + 1'b1;
          decision_next = decision + two_dy - two_adx;
        end else begin
          decision_next = decision - two_adx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left  <= '0;
      slope_class <= mlr_pkg::CLS_NONE;
    end else if (cmd.load) begin
      steps_left  <= n0;
      slope_class <= cls0;
    end else if (cmd.step) begin
      steps_left  <= steps_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x    <= x0;
      cur_y    <= y0;
      decision <= d0;
      two_adx  <= adx_w <<< 1;
      two_dy   <= dy_w <<< 1;
    end else if (cmd.step) begin
      cur_x    <= cur_x_next;
      cur_y    <= cur_y_next;
      decision <= decision_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_x    <= cur_x;
      out_y    <= cur_y;
      out_last <= (steps_left == CB'(1));
    end
  end

  assign m_tdata = OUT_W'({out_y, out_x});
  assign m_tlast = out_last;

  assign status.steps_zero = (steps_left == '0);
  assign status.last_step  = (steps_left == CB'(1));
  assign status.out_free   = !m_tvalid || m_tready;

  `MLR_ASSERT_IMP(a_no_overwrite, m_tvalid && !m_tready, !cmd.step)
  `MLR_ASSERT_IMP(a_no_step_when_done, cmd.step, steps_left != '0)
  `MLR_ASSERT_NXT(a_step_counts_down, cmd.step, steps_left == $past(steps_left) - 1'b1)

endmodule

// ----- rtl/core/midpoint_line_rasterizer.sv -----
// A taken request loads the walk registers; each step then registers a pixel at the output.
// The input is not ready again until the segment is fully walked; output stalls extend it.
// One pixel per cycle leaves the single shared midpoint step unit unless output stalls.
// A segment with both endpoints equal yields no pixel; the walk ends without a step.
// Reset (rst, synchronous, active high) empties the output register and idles the walk.
// Top level of the midpoint line rasterizer.
module midpoint_line_rasterizer #(
  parameter int COORD_BITS = 6,
  localparam int IN_W = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // Segment requests.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // x_start, y_start, x_end, y_end, zero fill
  // Pixel results.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // pixel_x, pixel_y, zero fill
  output logic             m_tlast   // last_pixel
);

  // The controller only sequences: it takes a request while the walk is idle,
  // then issues one step per cycle whenever the output register can accept a
  // pixel. The datapath computes the slope class and the scaled decision
  // variable at load time and walks one pixel per step. The output register
  // separates the walk from the consumer, so a new segment request can be
  // taken while the final pixel of the previous one still waits downstream.

  mlr_pkg::mlr_cmd_t    cmd;
  mlr_pkg::mlr_status_t status;

  mlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mlr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
